### rtl/core/spirf_pkg.sv
// Package for the SPI radio register and packet FIFO block.
// Holds request/response types, register addresses, flag and mode codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spirf_pkg;

    // Storage sizes
    localparam int FIFO_DEPTH = 256;
    localparam int REG_COUNT  = 128;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int REG_AW     = $clog2(REG_COUNT);

    // Request kinds
    localparam logic [1:0] KIND_SPI_BYTE = 2'd0;
    localparam logic [1:0] KIND_CS_REL   = 2'd1;
    localparam logic [1:0] KIND_TX_DONE  = 2'd2;
    localparam logic [1:0] KIND_RX_BYTE  = 2'd3;

    // Register addresses
    localparam logic [6:0] A_FIFO    = 7'h00;
    localparam logic [6:0] A_OPMODE  = 7'h01;
    localparam logic [6:0] A_PTR     = 7'h0d;
    localparam logic [6:0] A_RXBASE  = 7'h0f;
    localparam logic [6:0] A_RXCUR   = 7'h10;
    localparam logic [6:0] A_IRQ     = 7'h12;
    localparam logic [6:0] A_NBBYTES = 7'h13;
    localparam logic [6:0] A_PAYLEN  = 7'h22;
    localparam logic [6:0] A_VERSION = 7'h42;

    localparam logic [7:0] VERSION_VALUE = 8'h12;

    // Interrupt flags
    localparam logic [7:0] IRQ_TX_DONE = 8'h08;
    localparam logic [7:0] IRQ_RX_DONE = 8'h40;
    localparam logic [7:0] IRQ_CRC_ERR = 8'h20;

    // Operating modes
    localparam logic [2:0] MODE_STANDBY    = 3'd1;
    localparam logic [2:0] MODE_TX         = 3'd3;
    localparam logic [2:0] MODE_RX_CONT    = 3'd5;
    localparam logic [2:0] MODE_RX_ONESHOT = 3'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] spi_byte;
        logic [7:0] radio_byte;
        logic       rx_last;
        logic       crc_bad;
    } cmd_t;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic [7:0] irq_flags;
        logic [2:0] op_mode;
        logic       tx_start;
        logic [7:0] tx_length;
    } rsp_t;

    // True for either receive mode.
    function automatic logic is_rx(input logic [2:0] m);
        return (m == MODE_RX_CONT) || (m == MODE_RX_ONESHOT);
    endfunction

endpackage

`default_nettype wire

### rtl/core/spi_radio_register_fifo.sv
// Top level of the SPI radio register and packet FIFO block.
// Depends on spirf_pkg for types and constants.
//
//   port group   direction  handshake            payload
//   cmd          in         cmd_valid/cmd_stall   spirf_pkg::cmd_t
//   rsp          out        rsp_valid/rsp_stall   spirf_pkg::rsp_t
//
// Each request has two steps: the accept edge launches a read of the register
// memory and the FIFO memory, and the commit edge applies the change and writes back.
// One request is in flight at a time, so no two accesses overlap in the memories.
// The response sits in an output register; while it is stalled a finished request
// waits in the execute state, and a new request is still taken while idle.
// Reset clears control state and the register-file valid bits at once; there is
// no clearing pass. FIFO contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module spi_radio_register_fifo
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire spirf_pkg::cmd_t cmd,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output spirf_pkg::rsp_t      rsp
);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t          state_reg, state_next;
    spirf_pkg::cmd_t cmd_reg;
    spirf_pkg::rsp_t rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // Transaction and receive state
    logic       phase_reg, phase_next;
    logic [6:0] addr_reg, addr_next;
    logic       wr_acc_reg, wr_acc_next;
    logic [7:0] rx_ptr_reg, rx_ptr_next;
    logic [7:0] rx_cnt_reg, rx_cnt_next;
    logic [7:0] rx_start_reg, rx_start_next;

    // Registers with side effects, kept in flops
    logic [7:0] opmode_reg, opmode_next;
    logic [7:0] ptr_reg, ptr_next;
    logic [7:0] rxbase_reg, rxbase_next;
    logic [7:0] rxcur_reg, rxcur_next;
    logic [7:0] irq_reg, irq_next;
    logic [7:0] nbbytes_reg, nbbytes_next;
    logic [7:0] paylen_reg, paylen_next;

    // Plain register file memory with one valid bit per entry
    logic [7:0]                      regs_mem [spirf_pkg::REG_COUNT];
    logic [spirf_pkg::REG_COUNT-1:0] rvalid_reg, rvalid_next;
    logic [7:0]                      regs_rd_reg;
    logic                            regs_we;
    logic [spirf_pkg::REG_AW-1:0]    regs_idx;

    // Packet FIFO memory
    logic [7:0]                    fifo_mem [spirf_pkg::FIFO_DEPTH];
    logic [7:0]                    fifo_rd_reg;
    logic                          fifo_we;
    logic [spirf_pkg::FIFO_AW-1:0] fifo_waddr;
    logic [7:0]                    fifo_wdata;

    logic accept;
    logic commit;
    logic in_range;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign commit    = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign in_range  = ({1'b0, addr_reg} < 8'(spirf_pkg::REG_COUNT));
    assign regs_idx  = addr_reg[spirf_pkg::REG_AW-1:0];

    // Register file memory: read on accept, write on commit.
    always_ff @(posedge clk)
    begin
        if (regs_we)
        begin
            regs_mem[regs_idx] <= cmd_reg.spi_byte;
        end
        if (accept)
        begin
            regs_rd_reg <= regs_mem[regs_idx];
        end
    end

    // FIFO memory: host side reads at the pointer register.
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        if (accept)
        begin
            fifo_rd_reg <= fifo_mem[ptr_reg[spirf_pkg::FIFO_AW-1:0]];
        end
    end

    // Next-state logic for one request.
    always_comb
    begin
        logic [2:0] old_mode;
        logic [2:0] new_mode;
        logic [7:0] miso;
        logic       txs;
        logic [7:0] start_eff;
        logic [7:0] cnt_inc;
        logic [7:0] rd_val;

        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        phase_next     = phase_reg;
        addr_next      = addr_reg;
        wr_acc_next    = wr_acc_reg;
        rx_ptr_next    = rx_ptr_reg;
        rx_cnt_next    = rx_cnt_reg;
        rx_start_next  = rx_start_reg;
        opmode_next    = opmode_reg;
        ptr_next       = ptr_reg;
        rxbase_next    = rxbase_reg;
        rxcur_next     = rxcur_reg;
        irq_next       = irq_reg;
        nbbytes_next   = nbbytes_reg;
        paylen_next    = paylen_reg;
        rvalid_next    = rvalid_reg;
        regs_we        = 1'b0;
        fifo_we        = 1'b0;
        fifo_waddr     = ptr_reg[spirf_pkg::FIFO_AW-1:0];
        fifo_wdata     = cmd_reg.spi_byte;
        miso           = 8'h00;
        txs            = 1'b0;
        old_mode       = opmode_reg[2:0];
        new_mode       = cmd_reg.spi_byte[2:0];
        start_eff      = (rx_cnt_reg == 8'h00) ? rx_ptr_reg : rx_start_reg;
        cnt_inc        = (rx_cnt_reg == 8'hff) ? rx_cnt_reg : rx_cnt_reg + 8'd1;

        // Register read mux: flop-held registers first, then the memory.
        case (addr_reg)
            spirf_pkg::A_OPMODE:  rd_val = opmode_reg;
            spirf_pkg::A_PTR:     rd_val = ptr_reg;
            spirf_pkg::A_RXBASE:  rd_val = rxbase_reg;
            spirf_pkg::A_RXCUR:   rd_val = rxcur_reg;
            spirf_pkg::A_IRQ:     rd_val = irq_reg;
            spirf_pkg::A_NBBYTES: rd_val = nbbytes_reg;
            spirf_pkg::A_PAYLEN:  rd_val = paylen_reg;
            spirf_pkg::A_VERSION: rd_val = spirf_pkg::VERSION_VALUE;
            default:              rd_val = (in_range && rvalid_reg[regs_idx]) ? regs_rd_reg
                                                                               : 8'h00;
        endcase

        if (accept)
        begin
            state_next = ST_EXEC;
        end

        if (commit)
        begin
            case (cmd_reg.kind)
                spirf_pkg::KIND_SPI_BYTE:
                begin
                    if (!phase_reg)
                    begin
                        // Address byte opens the transaction.
                        addr_next   = cmd_reg.spi_byte[6:0];
                        wr_acc_next = cmd_reg.spi_byte[7];
                        phase_next  = 1'b1;
                    end
                    else if (addr_reg == spirf_pkg::A_FIFO)
                    begin
                        // FIFO access through the pointer register.
                        if (wr_acc_reg)
                        begin
                            fifo_we = 1'b1;
                        end
                        else
                        begin
                            miso = fifo_rd_reg;
                        end
                        ptr_next = ptr_reg + 8'd1;
                    end
                    else
                    begin
                        if (wr_acc_reg)
                        begin
                            if (in_range)
                            begin
                                case (addr_reg)
                                    spirf_pkg::A_VERSION,
                                    spirf_pkg::A_RXCUR,
                                    spirf_pkg::A_NBBYTES: ;
                                    spirf_pkg::A_IRQ:
                                        irq_next = irq_reg & ~cmd_reg.spi_byte;
                                    spirf_pkg::A_OPMODE:
                                    begin
                                        opmode_next = cmd_reg.spi_byte;
                                        if (spirf_pkg::is_rx(new_mode)
                                            && !spirf_pkg::is_rx(old_mode))
                                        begin
                                            rx_ptr_next = rxbase_reg;
                                            rx_cnt_next = 8'h00;
                                        end
                                        txs = (new_mode == spirf_pkg::MODE_TX)
                                              && (old_mode != spirf_pkg::MODE_TX);
                                    end
                                    spirf_pkg::A_PTR:    ptr_next    = cmd_reg.spi_byte;
                                    spirf_pkg::A_RXBASE: rxbase_next = cmd_reg.spi_byte;
                                    spirf_pkg::A_PAYLEN: paylen_next = cmd_reg.spi_byte;
                                    default:
                                    begin
                                        regs_we               = 1'b1;
                                        rvalid_next[regs_idx] = 1'b1;
                                    end
                                endcase
                            end
                        end
                        else if (in_range)
                        begin
                            miso = rd_val;
                        end
                        addr_next = addr_reg + 7'd1;
                    end
                end
                spirf_pkg::KIND_CS_REL:
                begin
                    phase_next = 1'b0;
                end
                spirf_pkg::KIND_TX_DONE:
                begin
                    if (old_mode == spirf_pkg::MODE_TX)
                    begin
                        irq_next    = irq_reg | spirf_pkg::IRQ_TX_DONE;
                        opmode_next = {opmode_reg[7:3], spirf_pkg::MODE_STANDBY};
                    end
                end
                default:
                begin
                    // Received radio byte goes into the FIFO at the modem pointer.
                    if (spirf_pkg::is_rx(old_mode))
                    begin
                        fifo_we     = 1'b1;
                        fifo_waddr  = rx_ptr_reg[spirf_pkg::FIFO_AW-1:0];
                        fifo_wdata  = cmd_reg.radio_byte;
                        rx_ptr_next = rx_ptr_reg + 8'd1;
                        if (cmd_reg.rx_last)
                        begin
                            irq_next     = irq_reg | spirf_pkg::IRQ_RX_DONE
                                           | (cmd_reg.crc_bad ? spirf_pkg::IRQ_CRC_ERR : 8'h00);
                            rxcur_next   = start_eff;
                            nbbytes_next = cnt_inc;
                            rx_cnt_next  = 8'h00;
                            if (old_mode == spirf_pkg::MODE_RX_ONESHOT)
                            begin
                                opmode_next = {opmode_reg[7:3], spirf_pkg::MODE_STANDBY};
                            end
                        end
                        else
                        begin
                            rx_start_next = start_eff;
                            rx_cnt_next   = cnt_inc;
                        end
                    end
                end
            endcase

            rsp_next.miso_byte = miso;
            rsp_next.irq_flags = irq_next;
            rsp_next.op_mode   = opmode_next[2:0];
            rsp_next.tx_start  = txs;
            rsp_next.tx_length = txs ? paylen_reg : 8'h00;
            rsp_valid_next     = 1'b1;
            state_next         = ST_IDLE;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // State, control registers and the registered response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            cmd_reg       <= '0;
            phase_reg     <= 1'b0;
            addr_reg      <= 7'h00;
            wr_acc_reg    <= 1'b0;
            rx_ptr_reg    <= 8'h00;
            rx_cnt_reg    <= 8'h00;
            rx_start_reg  <= 8'h00;
            opmode_reg    <= 8'h00;
            ptr_reg       <= 8'h00;
            rxbase_reg    <= 8'h00;
            rxcur_reg     <= 8'h00;
            irq_reg       <= 8'h00;
            nbbytes_reg   <= 8'h00;
            paylen_reg    <= 8'h00;
            rvalid_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            if (accept)
            begin
                cmd_reg <= cmd;
            end
            phase_reg     <= phase_next;
            addr_reg      <= addr_next;
            wr_acc_reg    <= wr_acc_next;
            rx_ptr_reg    <= rx_ptr_next;
            rx_cnt_reg    <= rx_cnt_next;
            rx_start_reg  <= rx_start_next;
            opmode_reg    <= opmode_next;
            ptr_reg       <= ptr_next;
            rxbase_reg    <= rxbase_next;
            rxcur_reg     <= rxcur_next;
            irq_reg       <= irq_next;
            nbbytes_reg   <= nbbytes_next;
            paylen_reg    <= paylen_next;
            rvalid_reg    <= rvalid_next;
        end
    end

    // An accepted request blocks the next one while it executes.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cmd_stall)
        else $error("request accepted without entering execute");

    // Finishing a request always leaves a valid response.
    a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (rsp_valid && !cmd_stall))
        else $error("commit did not produce a response");

    // A start pulse only reports entry into transmit mode.
    a_tx_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.tx_start) |-> (rsp.op_mode == spirf_pkg::MODE_TX))
        else $error("tx start without transmit mode");

    // Memories are written only while a request commits.
    a_write_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (regs_we || fifo_we) |-> commit)
        else $error("memory write outside commit");

endmodule

`default_nettype wire

### tb/spi_radio_register_fifo_tb.sv
// Self-checking testbench for spi_radio_register_fifo: directed and random requests
// are run against a cycle-free behavioral predictor of the radio's registers and FIFO.
// Depends on spirf_pkg and the spi_radio_register_fifo RTL.
`timescale 1ns / 1ps

module spi_radio_register_fifo_tb;

    import spirf_pkg::*;

    localparam int GAP_MAX     = 18;
    localparam int HOLD_CYCLES = 60;
    localparam logic ACC_WRITE = 1'b1;
    localparam logic ACC_READ  = 1'b0;
    localparam logic [6:0] A_LAST = 7'h7f;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Predicted chip state.
    logic [7:0] chip_regs [REG_COUNT];
    logic [7:0] chip_fifo [FIFO_DEPTH];
    bit         fifo_filled [FIFO_DEPTH];
    bit         spi_in_data;
    logic [6:0] spi_addr;
    logic       spi_write;
    logic [7:0] rx_wr_pos;
    logic [7:0] rx_len;
    logic [7:0] rx_head;

    rsp_t chip_replies [$];
    rsp_t want_reply;
    int   fault_count;
    int   items_sent;
    bit   idle_on;
    bit   idle_locked;
    bit   hold_req;

    spi_radio_register_fifo u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit in_rx_mode(input logic [2:0] m);
        return (m == MODE_RX_CONT) || (m == MODE_RX_ONESHOT);
    endfunction

    // Apply one request to the predicted state and return the reply it should produce.
    task automatic chip_apply(input cmd_t c, output rsp_t r);
        logic [7:0] miso;
        logic [7:0] p;
        logic [2:0] was;
        logic [2:0] next_mode;
        logic       fire;
        miso = 8'h00;
        fire = 1'b0;
        was  = chip_regs[A_OPMODE][2:0];
        case (c.kind)
            KIND_SPI_BYTE:
            begin
                if (!spi_in_data)
                begin
                    spi_addr    = c.spi_byte[6:0];
                    spi_write   = c.spi_byte[7];
                    spi_in_data = 1'b1;
                end
                else if (spi_addr == A_FIFO)
                begin
                    p = chip_regs[A_PTR];
                    if (spi_write)
                    begin
                        chip_fifo[p % FIFO_DEPTH]   = c.spi_byte;
                        fifo_filled[p % FIFO_DEPTH] = 1'b1;
                    end
                    else
                    begin
                        miso = chip_fifo[p % FIFO_DEPTH];
                    end
                    chip_regs[A_PTR] = p + 8'd1;
                end
                else
                begin
                    if (!spi_write)
                    begin
                        if (spi_addr < REG_COUNT)
                            miso = chip_regs[spi_addr];
                    end
                    else if (spi_addr == A_IRQ)
                    begin
                        // Ones clear flags, zeros keep them.
                        chip_regs[A_IRQ] = chip_regs[A_IRQ] & ~c.spi_byte;
                    end
                    else if (spi_addr == A_OPMODE)
                    begin
                        next_mode = c.spi_byte[2:0];
                        chip_regs[A_OPMODE] = c.spi_byte;
                        if (in_rx_mode(next_mode) && !in_rx_mode(was))
                        begin
                            rx_wr_pos = chip_regs[A_RXBASE];
                            rx_len    = 8'd0;
                        end
                        fire = (next_mode == MODE_TX) && (was != MODE_TX);
                    end
                    else if (spi_addr < REG_COUNT && spi_addr != A_VERSION
                             && spi_addr != A_RXCUR && spi_addr != A_NBBYTES)
                    begin
                        chip_regs[spi_addr] = c.spi_byte;
                    end
                    spi_addr = spi_addr + 7'd1;
                end
            end
            KIND_CS_REL:
            begin
                spi_in_data = 1'b0;
            end
            KIND_TX_DONE:
            begin
                if (was == MODE_TX)
                begin
                    chip_regs[A_IRQ] = chip_regs[A_IRQ] | IRQ_TX_DONE;
                    chip_regs[A_OPMODE][2:0] = MODE_STANDBY;
                end
            end
            default:
            begin
                // Received radio byte, only taken in a receive mode.
                if (in_rx_mode(was))
                begin
                    if (rx_len == 8'd0)
                        rx_head = rx_wr_pos;
                    chip_fifo[rx_wr_pos % FIFO_DEPTH]   = c.radio_byte;
                    fifo_filled[rx_wr_pos % FIFO_DEPTH] = 1'b1;
                    rx_wr_pos = rx_wr_pos + 8'd1;
                    if (rx_len != 8'hff)
                        rx_len = rx_len + 8'd1;
                    if (c.rx_last)
                    begin
                        chip_regs[A_IRQ] = chip_regs[A_IRQ] | IRQ_RX_DONE
                                           | (c.crc_bad ? IRQ_CRC_ERR : 8'h00);
                        chip_regs[A_RXCUR]   = rx_head;
                        chip_regs[A_NBBYTES] = rx_len;
                        rx_len = 8'd0;
                        if (was == MODE_RX_ONESHOT)
                            chip_regs[A_OPMODE][2:0] = MODE_STANDBY;
                    end
                end
            end
        endcase
        r.miso_byte = miso;
        r.irq_flags = chip_regs[A_IRQ];
        r.op_mode   = chip_regs[A_OPMODE][2:0];
        r.tx_start  = fire;
        r.tx_length = fire ? chip_regs[A_PAYLEN] : 8'h00;
    endtask

    function automatic cmd_t random_request();
        logic [31:0] raw;
        raw = $urandom;
        return cmd_t'(raw[$bits(cmd_t)-1:0]);
    endfunction

    function automatic logic [7:0] opmode_value(input logic [2:0] m);
        logic [7:0] v;
        v = 8'($urandom);
        v[2:0] = m;
        return v;
    endfunction

    // Offer one request at a falling edge and hold it until the block takes it.
    task automatic send_request(input cmd_t c);
        rsp_t want;
        // Reading a FIFO entry that was never written is not allowed; end the access instead.
        if (c.kind == KIND_SPI_BYTE && spi_in_data && spi_addr == A_FIFO && !spi_write
            && !fifo_filled[chip_regs[A_PTR] % FIFO_DEPTH])
            c.kind = KIND_CS_REL;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        chip_apply(c, want);
        chip_replies.push_back(want);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic spi(input logic [7:0] b);
        cmd_t c;
        c = random_request();
        c.kind = KIND_SPI_BYTE;
        c.spi_byte = b;
        send_request(c);
    endtask

    task automatic spi_cs();
        cmd_t c;
        c = random_request();
        c.kind = KIND_CS_REL;
        send_request(c);
    endtask

    task automatic tx_done();
        cmd_t c;
        c = random_request();
        c.kind = KIND_TX_DONE;
        send_request(c);
    endtask

    task automatic radio_rx(input logic [7:0] b, input logic last, input logic bad);
        cmd_t c;
        c = random_request();
        c.kind       = KIND_RX_BYTE;
        c.radio_byte = b;
        c.rx_last    = last;
        c.crc_bad    = bad;
        send_request(c);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (chip_replies.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    // Random traffic: mostly framed accesses and radio sequences, some raw noise.
    task automatic run_traffic(input int n);
        int stop_at;
        int pick;
        int len;
        logic [7:0] v;
        logic [6:0] a;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if (!idle_locked && $urandom_range(0, 19) == 0)
                idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                a = 7'($urandom);
                case ($urandom_range(0, 11))
                    0:  a = A_FIFO;
                    1:  a = A_FIFO;
                    2:  a = A_OPMODE;
                    3:  a = A_PTR;
                    4:  a = A_RXBASE;
                    5:  a = A_RXCUR;
                    6:  a = A_IRQ;
                    7:  a = A_NBBYTES;
                    8:  a = A_PAYLEN;
                    9:  a = A_VERSION;
                    10: a = A_LAST;
                    default: ;
                endcase
                spi_cs();
                spi({$urandom_range(0, 1) ? ACC_WRITE : ACC_READ, a});
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
                repeat (len)
                begin
                    v = 8'($urandom);
                    if (a == A_OPMODE && $urandom_range(0, 1) == 1)
                    begin
                        case ($urandom_range(0, 3))
                            0: v = opmode_value(MODE_STANDBY);
                            1: v = opmode_value(MODE_TX);
                            2: v = opmode_value(MODE_RX_CONT);
                            default: v = opmode_value(MODE_RX_ONESHOT);
                        endcase
                    end
                    spi(v);
                end
                if ($urandom_range(0, 9) != 0)
                    spi_cs();
            end
            else if (pick < 65)
            begin
                // Transmit: mostly set a length and enter TX, then the modem reports done.
                if ($urandom_range(0, 4) != 0)
                begin
                    spi_cs();
                    spi({ACC_WRITE, A_PAYLEN});
                    spi(8'($urandom));
                    spi_cs();
                    spi({ACC_WRITE, A_OPMODE});
                    spi(opmode_value(MODE_TX));
                    spi_cs();
                end
                tx_done();
            end
            else if (pick < 85)
            begin
                // Receive: enter an RX mode if needed, then a short packet.
                if (!in_rx_mode(chip_regs[A_OPMODE][2:0]))
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        spi_cs();
                        spi({ACC_WRITE, A_RXBASE});
                        spi(8'($urandom));
                    end
                    spi_cs();
                    spi({ACC_WRITE, A_OPMODE});
                    spi(opmode_value($urandom_range(0, 1) ? MODE_RX_CONT : MODE_RX_ONESHOT));
                    spi_cs();
                end
                len = $urandom_range(1, 8);
                for (int k = 1; k <= len; k++)
                    radio_rx(8'($urandom), (k == len) && ($urandom_range(0, 6) != 0),
                             1'($urandom_range(0, 1)));
            end
            else
            begin
                send_request(random_request());
            end
        end
    endtask

    // FIFO writes at the data extremes, pointer reload, then read back.
    task automatic test_fifo_access();
        spi({ACC_WRITE, A_FIFO});
        spi(8'h00);
        spi(8'hff);
        spi_cs();
        spi({ACC_WRITE, A_PTR});
        spi(8'h00);
        spi_cs();
        spi({ACC_READ, A_FIFO});
        spi(8'h00);
        spi(8'h00);
    endtask

    // Read-only registers, IRQ write-one-to-clear, and the burst wrap into the FIFO.
    task automatic test_register_rules();
        spi_cs();
        spi({ACC_WRITE, A_RXCUR});
        spi(8'hff);
        spi(8'h00);
        spi(8'hff);
        spi(8'hff);
        spi_cs();
        spi({ACC_WRITE, A_VERSION});
        spi(8'hff);
        spi_cs();
        spi({ACC_WRITE, A_LAST - 7'd1});
        spi(8'h5a);
        spi(8'ha5);
        spi(8'h3c);
    endtask

    // Entering TX pulses start; done sets the flag and drops to standby.
    task automatic test_tx_cycle();
        spi_cs();
        spi({ACC_WRITE, A_OPMODE});
        spi({5'd0, MODE_TX});
        spi_cs();
        tx_done();
        tx_done();
    endtask

    // Single-packet receive with pointer wrap and a CRC error, then a stray byte.
    task automatic test_rx_packet();
        spi_cs();
        spi({ACC_WRITE, A_RXBASE});
        spi(8'hfe);
        spi_cs();
        spi({ACC_WRITE, A_OPMODE});
        spi({5'd0, MODE_RX_ONESHOT});
        radio_rx(8'h00, 1'b0, 1'b0);
        radio_rx(8'hff, 1'b1, 1'b1);
        radio_rx(8'h77, 1'b1, 1'b0);
    endtask

    // A packet longer than the byte counter fills every FIFO entry and saturates the count.
    task automatic test_long_packet();
        spi_cs();
        spi({ACC_WRITE, A_OPMODE});
        spi(opmode_value(MODE_RX_CONT));
        spi_cs();
        for (int k = 0; k < 257; k++)
            radio_rx(8'($urandom), k == 256, 1'($urandom_range(0, 1)));
        spi({ACC_WRITE, A_OPMODE});
        spi(opmode_value(MODE_STANDBY));
        spi_cs();
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_hold();
        bit saved;
        saved   = idle_on;
        idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (14) send_request(random_request());
        idle_on = saved;
    endtask

    // Sender stops until every reply has come back, then resumes.
    task automatic test_drain_pause();
        run_traffic(10);
        wait_drained();
        run_traffic(10);
    endtask

    task automatic test_random_traffic();
        idle_on = 1'b1;
        run_traffic(44);
    endtask

    // Full rate on both sides to finish.
    task automatic test_full_rate_tail();
        idle_locked = 1'b1;
        idle_on     = 1'b0;
        run_traffic(20);
    endtask

    // Reply checker: each accepted reply against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (chip_replies.size() == 0)
            begin
                $display("%0t: reply with no request outstanding, got %p", $time, rsp);
                fault_count++;
            end
            else
            begin
                want_reply = chip_replies.pop_front();
                if (rsp.miso_byte !== want_reply.miso_byte)
                begin
                    $display("%0t: miso_byte expected %h, got %h",
                             $time, want_reply.miso_byte, rsp.miso_byte);
                    fault_count++;
                end
                if (rsp.irq_flags !== want_reply.irq_flags)
                begin
                    $display("%0t: irq_flags expected %h, got %h",
                             $time, want_reply.irq_flags, rsp.irq_flags);
                    fault_count++;
                end
                if (rsp.op_mode !== want_reply.op_mode)
                begin
                    $display("%0t: op_mode expected %h, got %h",
                             $time, want_reply.op_mode, rsp.op_mode);
                    fault_count++;
                end
                if (rsp.tx_start !== want_reply.tx_start)
                begin
                    $display("%0t: tx_start expected %b, got %b",
                             $time, want_reply.tx_start, rsp.tx_start);
                    fault_count++;
                end
                if (rsp.tx_length !== want_reply.tx_length)
                begin
                    $display("%0t: tx_length expected %h, got %h",
                             $time, want_reply.tx_length, rsp.tx_length);
                    fault_count++;
                end
            end
        end
    end

    // Reply side back-pressure: random stall bursts and a requested long hold.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, GAP_MAX - 1);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    initial
    begin
        #1_000_000;
        $display("spi_radio_register_fifo: mismatch");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        fault_count = 0;
        items_sent  = 0;
        idle_on     = 1'b0;
        idle_locked = 1'b0;
        hold_req    = 1'b0;

        // Predicted state after reset.
        foreach (chip_regs[i])
            chip_regs[i] = 8'h00;
        chip_regs[A_VERSION] = VERSION_VALUE;
        foreach (chip_fifo[i])
        begin
            chip_fifo[i]   = 8'h00;
            fifo_filled[i] = 1'b0;
        end
        spi_in_data = 1'b0;
        spi_addr    = 7'd0;
        spi_write   = 1'b0;
        rx_wr_pos   = 8'd0;
        rx_len      = 8'd0;
        rx_head     = 8'd0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_fifo_access();
        test_register_rules();
        test_tx_cycle();
        test_rx_packet();
        test_long_packet();
        test_output_hold();
        test_drain_pause();
        test_random_traffic();
        test_full_rate_tail();

        // Let the last replies come back.
        cmd_valid <= 1'b0;
        while (chip_replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("spi_radio_register_fifo: match");
        else
            $display("spi_radio_register_fifo: mismatch");
        $finish;
    end

endmodule

### spi_radio_register_fifo.f
rtl/core/spirf_pkg.sv
rtl/core/spi_radio_register_fifo.sv
tb/spi_radio_register_fifo_tb.sv
